>>> sv/sphere_grid_insert_with_culling_top_defines.svh
// Assertion macros shared by the sphere grid RTL
`ifndef SPHERE_GRID_INSERT_WITH_CULLING_TOP_DEFINES_SVH
`define SPHERE_GRID_INSERT_WITH_CULLING_TOP_DEFINES_SVH

// same-cycle implication, checked out of reset
`define SGI_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define SGI_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> sv/sgi_pkg.sv
// Package: defaults, constants and types of the sphere grid block
`timescale 1ns / 1ps
package sgi_pkg;
   localparam int GRID_PER_AXIS_DEF = 10;
   localparam int CELL_CAPACITY_DEF = 16;
   localparam int COORD_BITS        = 16;
   localparam int EPS               = ((1 << COORD_BITS) + 500) / 1000;
   localparam logic [15:0] CELL_SIZE_RESET   = 16'd6554;
   localparam logic [4:0]  GRID_EXTENT_RESET = 5'd10;
   localparam logic [0:0]  REG_CELL_SIZE     = 1'b0;
   localparam logic [0:0]  REG_GRID_EXTENT   = 1'b1;

   typedef struct packed {
      logic [COORD_BITS-1:0] r;
      logic [COORD_BITS-1:0] z;
      logic [COORD_BITS-1:0] y;
      logic [COORD_BITS-1:0] x;
   } ball_type;
endpackage

>>> sv/sphere_grid_insert_with_culling_top.sv
// Top level: sphere insertion into a uniform grid with containment culling
//
//  channel | dir | beat contents (lsb first)
//  req_    | in  | tdata: sphere_x[15:0] sphere_y sphere_z sphere_radius
//  rsp_    | out | tdata: accepted, removed_count[8:0], overflow, home_cell[11:0], pad
//  csr_    | in  | we, addr (0 cell_size, 1 grid_extent), wdata[15:0]
//
// Per beat: home cell by repeated subtraction, one axis after another; then a walk
// over the 27 neighbour offsets, reading the fill count of each cell in range and
// testing each stored entry (read, data, four passes of the shared squarer, test);
// after a rejection the rest of that cell is closed up untested and the home append
// is skipped. Otherwise the home append follows, then the result.
// After reset a clearing pass zeroes the fill counts; req_tready
// stays low meanwhile. One beat at a time: req_tready is high only when idle.
// A result holds on rsp_ until rsp_tready takes it.
`timescale 1ns / 1ps
`include "sphere_grid_insert_with_culling_top_defines.svh"
module sphere_grid_insert_with_culling_top #(
   parameter int GRID_PER_AXIS = sgi_pkg::GRID_PER_AXIS_DEF,
   parameter int CELL_CAPACITY = sgi_pkg::CELL_CAPACITY_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,  // sphere_x, sphere_y, sphere_z, sphere_radius
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // accepted, removed_count, overflow, home_cell, 0
   input  logic        csr_we,
   input  logic [0:0]  csr_addr,
   input  logic [15:0] csr_wdata
);
   localparam int G   = GRID_PER_AXIS;
   localparam int CAP = CELL_CAPACITY;
   localparam int NC  = G * G * G;
   localparam int IW  = $clog2(NC);
   localparam int AW  = $clog2(NC * CAP);
   localparam int HW  = $clog2(G);
   localparam int CW  = $clog2(G + 2);
   localparam int NW  = $clog2(CAP + 1);
   localparam int CB  = sgi_pkg::COORD_BITS;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_DIV   = 4'd2;
   localparam logic [3:0] S_CELL  = 4'd3;
   localparam logic [3:0] S_FILL  = 4'd4;
   localparam logic [3:0] S_RD    = 4'd5;
   localparam logic [3:0] S_DAT   = 4'd6;
   localparam logic [3:0] S_MUL   = 4'd7;
   localparam logic [3:0] S_TST   = 4'd8;
   localparam logic [3:0] S_HOME  = 4'd9;
   localparam logic [3:0] S_HFILL = 4'd10;
   localparam logic [3:0] S_OUT   = 4'd11;

   // memories
   logic [NW-1:0]            fill_mem [NC];
   sgi_pkg::ball_type        slot_mem [NC*CAP];

   logic [3:0]  state_ff, state_in;
   logic [15:0] csize_ff, csize_in;
   logic [4:0]  extent_ff, extent_in;
   sgi_pkg::ball_type cand_ff, cand_in, ent_ff, ent_in;
   logic [1:0]  axis_ff, axis_in;
   logic [HW-1:0] q_ff, q_in;
   logic [CB-1:0] rem_ff, rem_in;
   logic [HW-1:0] hx_ff, hx_in, hy_ff, hy_in, hz_ff, hz_in;
   logic [1:0]  oi_ff, oi_in, oj_ff, oj_in, ok_ff, ok_in;
   logic        fin_ff, fin_in;
   logic [IW-1:0] idx_ff, idx_in, clr_ff, clr_in;
   logic [NW-1:0] n_ff, n_in, r_ff, r_in, w_ff, w_in;
   logic        rej_ff, rej_in;
   logic [1:0]  step_ff, step_in;
   logic [33:0] prod_ff, prod_in;
   logic [34:0] acc_ff, acc_in;
   logic [8:0]  removed_ff, removed_in;
   logic        accd_ff, accd_in, ovf_ff, ovf_in;

   logic [NW-1:0] fill_rd_ff;
   sgi_pkg::ball_type slot_rd_ff;

   // memory port controls
   logic          fill_we;
   logic [IW-1:0] fill_waddr, fill_raddr;
   logic [NW-1:0] fill_wdata;
   logic          slot_we;
   logic [AW-1:0] slot_waddr, slot_raddr;
   sgi_pkg::ball_type slot_wdata;

   // neighbour cell coordinates, offset by one so that -1 stays non-negative
   logic [CW-1:0] cx, cy, cz;
   logic          in_range;
   logic [IW-1:0] nidx, home;
   logic          last_off;
   logic [16:0]   sq_op;
   logic [CB-1:0] dx, dy, dz;
   logic [16:0]   lim;
   logic          contained;

   assign cx = CW'(hx_ff) + CW'(oi_ff);
   assign cy = CW'(hy_ff) + CW'(oj_ff);
   assign cz = CW'(hz_ff) + CW'(ok_ff);
   assign in_range = (cx != '0) && (cy != '0) && (cz != '0)
                  && (6'(cx) - 6'd1 < 6'(extent_ff)) && (6'(cx) - 6'd1 < 6'(G))
                  && (6'(cy) - 6'd1 < 6'(extent_ff)) && (6'(cy) - 6'd1 < 6'(G))
                  && (6'(cz) - 6'd1 < 6'(extent_ff)) && (6'(cz) - 6'd1 < 6'(G));
   assign nidx = (IW'(cx) - IW'(1)) * IW'(G) * IW'(G)
               + (IW'(cy) - IW'(1)) * IW'(G) + (IW'(cz) - IW'(1));
   assign home = IW'(hx_ff) * IW'(G) * IW'(G) + IW'(hy_ff) * IW'(G) + IW'(hz_ff);
   assign last_off = (oi_ff == 2'd2) && (oj_ff == 2'd2) && (ok_ff == 2'd2);

   assign dx  = (cand_ff.x > ent_ff.x) ? cand_ff.x - ent_ff.x : ent_ff.x - cand_ff.x;
   assign dy  = (cand_ff.y > ent_ff.y) ? cand_ff.y - ent_ff.y : ent_ff.y - cand_ff.y;
   assign dz  = (cand_ff.z > ent_ff.z) ? cand_ff.z - ent_ff.z : ent_ff.z - cand_ff.z;
   assign lim = ((cand_ff.r > ent_ff.r) ? 17'(cand_ff.r - ent_ff.r)
                                        : 17'(ent_ff.r - cand_ff.r)) + 17'(sgi_pkg::EPS);
   assign contained = acc_ff <= {1'b0, prod_ff};

   // shared squarer operand
   always_comb begin
      unique case (step_ff)
         2'd0:    sq_op = 17'(dx);
         2'd1:    sq_op = 17'(dy);
         2'd2:    sq_op = 17'(dz);
         default: sq_op = lim;
      endcase
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {1'b0, 12'(home), ovf_ff, removed_ff, accd_ff};

   always_comb begin
      state_in   = state_ff;
      csize_in   = csize_ff;
      extent_in  = extent_ff;
      cand_in    = cand_ff;
      ent_in     = ent_ff;
      axis_in    = axis_ff;
      q_in       = q_ff;
      rem_in     = rem_ff;
      hx_in      = hx_ff;
      hy_in      = hy_ff;
      hz_in      = hz_ff;
      oi_in      = oi_ff;
      oj_in      = oj_ff;
      ok_in      = ok_ff;
      fin_in     = fin_ff;
      idx_in     = idx_ff;
      clr_in     = clr_ff;
      n_in       = n_ff;
      r_in       = r_ff;
      w_in       = w_ff;
      rej_in     = rej_ff;
      step_in    = step_ff;
      prod_in    = prod_ff;
      acc_in     = acc_ff;
      removed_in = removed_ff;
      accd_in    = accd_ff;
      ovf_in     = ovf_ff;
      fill_we    = 1'b0;
      fill_waddr = idx_ff;
      fill_wdata = w_ff;
      fill_raddr = nidx;
      slot_we    = 1'b0;
      slot_waddr = AW'(idx_ff) * AW'(CAP) + AW'(w_ff);
      slot_wdata = slot_rd_ff;
      slot_raddr = AW'(idx_ff) * AW'(CAP) + AW'(r_ff);

      if (csr_we) begin
         unique case (csr_addr)
            sgi_pkg::REG_CELL_SIZE:   csize_in  = csr_wdata;
            sgi_pkg::REG_GRID_EXTENT: extent_in = csr_wdata[4:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         S_CLEAR: begin
            fill_we    = 1'b1;
            fill_waddr = clr_ff;
            fill_wdata = '0;
            clr_in     = clr_ff + IW'(1);
            if (clr_ff == IW'(NC - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid) begin
               cand_in    = req_tdata;
               rem_in     = req_tdata[CB-1:0];
               q_in       = '0;
               axis_in    = 2'd0;
               removed_in = '0;
               accd_in    = 1'b0;
               ovf_in     = 1'b0;
               rej_in     = 1'b0;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            // saturating quotient; a zero divisor runs to the top cell
            if ((q_ff != HW'(G - 1)) && (rem_ff >= csize_ff)) begin
               rem_in = rem_ff - csize_ff;
               q_in   = q_ff + HW'(1);
            end else begin
               q_in    = '0;
               axis_in = axis_ff + 2'd1;
               unique case (axis_ff)
                  2'd0: begin
                     hx_in  = q_ff;
                     rem_in = cand_ff.y;
                  end
                  2'd1: begin
                     hy_in  = q_ff;
                     rem_in = cand_ff.z;
                  end
                  default: begin
                     hz_in    = q_ff;
                     oi_in    = '0;
                     oj_in    = '0;
                     ok_in    = '0;
                     state_in = S_CELL;
                  end
               endcase
            end
         end
         S_CELL: begin
            idx_in = nidx;
            // remembers whether the cell being visited is the final offset
            fin_in = last_off;
            if (in_range) begin
               state_in = S_FILL;
            end else if (last_off) begin
               state_in = S_HOME;
            end
            if (ok_ff != 2'd2) begin
               ok_in = ok_ff + 2'd1;
            end else begin
               ok_in = '0;
               if (oj_ff != 2'd2) begin
                  oj_in = oj_ff + 2'd1;
               end else begin
                  oj_in = '0;
                  oi_in = oi_ff + 2'd1;
               end
            end
         end
         S_FILL: begin
            n_in     = fill_rd_ff;
            r_in     = '0;
            w_in     = '0;
            state_in = S_RD;
         end
         S_RD: begin
            if (r_ff == n_ff) begin
               fill_we = 1'b1;
               if (rej_ff) begin
                  state_in = S_OUT;
               end else if (fin_ff) begin
                  state_in = S_HOME;
               end else begin
                  state_in = S_CELL;
               end
            end else begin
               state_in = S_DAT;
            end
         end
         S_DAT: begin
            ent_in = slot_rd_ff;
            if (rej_ff) begin
               // walk stopped: close up the rest of the cell untested
               slot_we  = 1'b1;
               w_in     = w_ff + NW'(1);
               r_in     = r_ff + NW'(1);
               state_in = S_RD;
            end else begin
               step_in  = 2'd0;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            prod_in = 34'(sq_op) * 34'(sq_op);
            if (step_ff == 2'd1) acc_in = 35'(prod_ff);
            else if (step_ff != 2'd0) acc_in = acc_ff + 35'(prod_ff);
            step_in = step_ff + 2'd1;
            if (step_ff == 2'd3) state_in = S_TST;
         end
         S_TST: begin
            r_in       = r_ff + NW'(1);
            state_in   = S_RD;
            slot_wdata = ent_ff;
            if (contained && (cand_ff.r > ent_ff.r)) begin
               if (removed_ff != 9'h1FF) removed_in = removed_ff + 9'd1;
            end else begin
               if (contained) rej_in = 1'b1;
               slot_we = 1'b1;
               w_in    = w_ff + NW'(1);
            end
         end
         S_HOME: begin
            fill_raddr = home;
            idx_in     = home;
            state_in   = S_HFILL;
         end
         S_HFILL: begin
            if (fill_rd_ff >= NW'(CAP)) begin
               ovf_in = 1'b1;
            end else begin
               accd_in    = 1'b1;
               fill_we    = 1'b1;
               fill_wdata = fill_rd_ff + NW'(1);
               slot_we    = 1'b1;
               slot_waddr = AW'(idx_ff) * AW'(CAP) + AW'(fill_rd_ff);
               slot_wdata = cand_ff;
            end
            state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_CLEAR;
         clr_ff    <= '0;
         csize_ff  <= sgi_pkg::CELL_SIZE_RESET;
         extent_ff <= sgi_pkg::GRID_EXTENT_RESET;
      end else begin
         state_ff  <= state_in;
         clr_ff    <= clr_in;
         csize_ff  <= csize_in;
         extent_ff <= extent_in;
      end
      cand_ff    <= cand_in;
      ent_ff     <= ent_in;
      axis_ff    <= axis_in;
      q_ff       <= q_in;
      rem_ff     <= rem_in;
      hx_ff      <= hx_in;
      hy_ff      <= hy_in;
      hz_ff      <= hz_in;
      oi_ff      <= oi_in;
      oj_ff      <= oj_in;
      ok_ff      <= ok_in;
      fin_ff     <= fin_in;
      idx_ff     <= idx_in;
      n_ff       <= n_in;
      r_ff       <= r_in;
      w_ff       <= w_in;
      rej_ff     <= rej_in;
      step_ff    <= step_in;
      prod_ff    <= prod_in;
      acc_ff     <= acc_in;
      removed_ff <= removed_in;
      accd_ff    <= accd_in;
      ovf_ff     <= ovf_in;
   end

   // fill counts: one write, one registered read
   always_ff @(posedge clock) begin
      if (fill_we) fill_mem[fill_waddr] <= fill_wdata;
      fill_rd_ff <= fill_mem[fill_raddr];
   end

   // stored entries: one write, one registered read
   always_ff @(posedge clock) begin
      if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
      slot_rd_ff <= slot_mem[slot_raddr];
   end

   `SGI_ASSERT_IMP(a_busy_not_ready, clock, reset, rsp_tvalid, !req_tready, "ready while result pending")
   `SGI_ASSERT_IMP(a_compact_order, clock, reset, state_ff == S_TST, w_ff <= r_ff, "write pointer ahead of read")
   `SGI_ASSERT_IMP(a_acc_ovf, clock, reset, rsp_tvalid, !(accd_ff && ovf_ff), "accepted and overflow together")
   `SGI_ASSERT_NXT(a_start_div, clock, reset, req_tvalid && req_tready, state_ff == S_DIV, "beat taken without divide")
endmodule
